FILE: sv/wat_pkg.sv
// shared constants and state types for the windowed average threshold monitor
`default_nettype none
package wat_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int FILL_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_HUM_THRESH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUST_THRESH = 2'd1;

  localparam logic [SAMPLE_W-1:0] HUM_THRESH_RST  = 10'd600;
  localparam logic [SAMPLE_W-1:0] DUST_THRESH_RST = 10'd300;

  typedef enum logic {
    FR_IDLE,
    FR_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/wat_sample_if.sv
// request channel carrying one humidity and dust sample pair
`default_nettype none
interface wat_sample_if;
  logic       valid;
  logic       ready;
  logic [9:0] humidity_sample;
  logic [9:0] dust_sample;

  modport source (output valid, output humidity_sample, output dust_sample, input ready);
  modport sink   (input valid, input humidity_sample, input dust_sample, output ready);
endinterface
`default_nettype wire

FILE: sv/wat_result_if.sv
// request channel carrying one set of alarms and window averages
`default_nettype none
interface wat_result_if;
  logic       valid;
  logic       ready;
  logic       humidity_alarm;
  logic       dust_alarm;
  logic [9:0] average_humidity;
  logic [9:0] average_dust;
  logic       average_humidity_alarm;
  logic       average_dust_alarm;
  logic [4:0] window_fill;

  modport source (
    output valid, output humidity_alarm, output dust_alarm, output average_humidity,
    output average_dust, output average_humidity_alarm, output average_dust_alarm,
    output window_fill, input ready
  );
  modport sink (
    input valid, input humidity_alarm, input dust_alarm, input average_humidity,
    input average_dust, input average_humidity_alarm, input average_dust_alarm,
    input window_fill, output ready
  );
endinterface
`default_nettype wire

FILE: sv/windowed_average_threshold_monitor_top.sv
// top level of the windowed average threshold monitor
// usage:
//   in_req carries one humidity/dust sample pair per request (valid/ready).
//   out_req returns one result per sample: instant alarms, window averages,
//   average alarms and the window fill count, in request order.
//   cfg_wr_en/cfg_index/cfg_data write the humidity limit (index 0) and the
//   dust limit (index 1); other indexes are ignored. write only while idle.
// timing:
//   the front end takes a sample, pushes its job, and updates the ring and totals.
//   the back end divides both totals by the fill count bit-serially, one
//   quotient bit per cycle, and takes no new job until the result is
//   loaded into the output register. this divider sets the sustained rate.
// reset:
//   rst_n clears the window, totals and fill count and loads limits 600 and 300.
// stall:
//   results wait in the output register; a two-entry queue lets the front
//   end keep taking samples until it fills, then in_req.ready drops.
`default_nettype none
module windowed_average_threshold_monitor_top #(
  parameter int WINDOW_DEPTH = 20
) (
  input  wire                         clk,
  input  wire                         rst_n,
  wat_sample_if.sink                  in_req,
  wat_result_if.source                out_req,
  input  wire                         cfg_wr_en,
  input  wire [wat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [wat_pkg::CFG_W-1:0]    cfg_data
);
  import wat_pkg::*;

  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = 10 + CNT_W;
  localparam int JOB_W   = 20 + 2 * TOTAL_W + CNT_W;

  logic [SAMPLE_W-1:0] hum_thresh_r, dust_thresh_r;

  logic             fj_valid, fj_ready;
  logic [JOB_W-1:0] fj_data;
  logic             bj_valid, bj_ready;
  logic [JOB_W-1:0] bj_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hum_thresh_r  <= HUM_THRESH_RST;
      dust_thresh_r <= DUST_THRESH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HUM_THRESH:  hum_thresh_r  <= cfg_data;
        CFG_DUST_THRESH: dust_thresh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  wat_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job_data  (fj_data)
  );

  wat_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fj_valid),
    .push_ready (fj_ready),
    .push_data  (fj_data),
    .pop_valid  (bj_valid),
    .pop_ready  (bj_ready),
    .pop_data   (bj_data)
  );

  wat_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (bj_valid),
    .job_ready   (bj_ready),
    .job_data    (bj_data),
    .hum_thresh  (hum_thresh_r),
    .dust_thresh (dust_thresh_r),
    .out_req     (out_req)
  );

endmodule
`default_nettype wire

FILE: sv/wat_front.sv
// front end: sample ring, running totals and fill count, one job per request
`default_nettype none
module wat_front #(
  parameter int  WINDOW_DEPTH = 20,
  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1,
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1),
  localparam int TOTAL_W = 10 + CNT_W,
  localparam int JOB_W   = 20 + 2 * TOTAL_W + CNT_W
) (
  input  wire               clk,
  input  wire               rst_n,
  wat_sample_if.sink        in_req,
  output logic              job_valid,
  input  wire               job_ready,
  output logic [JOB_W-1:0]  job_data
);
  import wat_pkg::*;

  front_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0]   hum_r, dust_r;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [TOTAL_W-1:0]    htot_r, htot_nxt, dtot_r, dtot_nxt;
  logic [2*SAMPLE_W-1:0] ring_mem [WINDOW_DEPTH];
  logic [2*SAMPLE_W-1:0] old_r;
  logic                  take;
  logic                  commit;
  logic                  full;

  assign take = in_req.valid && in_req.ready;
  assign full = (fill_r == CNT_W'(WINDOW_DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FR_IDLE: if (in_req.valid) state_nxt = FR_PUSH;
      FR_PUSH: if (job_ready) state_nxt = FR_IDLE;
      default: state_nxt = FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_req.ready = 1'b0;
    job_valid    = 1'b0;
    case (state_r)
      FR_IDLE: in_req.ready = 1'b1;
      FR_PUSH: job_valid    = 1'b1;
      default: ;
    endcase
  end

  assign commit = job_valid && job_ready;

  always_comb begin
    htot_nxt = htot_r + TOTAL_W'(hum_r);
    dtot_nxt = dtot_r + TOTAL_W'(dust_r);
    fill_nxt = fill_r;
    if (full) begin
      htot_nxt = htot_nxt - TOTAL_W'(old_r[2*SAMPLE_W-1:SAMPLE_W]);
      dtot_nxt = dtot_nxt - TOTAL_W'(old_r[SAMPLE_W-1:0]);
    end else begin
      fill_nxt = fill_r + CNT_W'(1);
    end
    slot_nxt = (slot_r == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
  end

  assign job_data = {hum_r, dust_r, htot_nxt, dtot_nxt, fill_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
      slot_r  <= '0;
      fill_r  <= '0;
      htot_r  <= '0;
      dtot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        slot_r <= slot_nxt;
        fill_r <= fill_nxt;
        htot_r <= htot_nxt;
        dtot_r <= dtot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hum_r  <= in_req.humidity_sample;
      dust_r <= in_req.dust_sample;
    end
  end

  // ring memory, registered read of the oldest slot
  always_ff @(posedge clk) begin
    if (commit) ring_mem[slot_r] <= {hum_r, dust_r};
    old_r <= ring_mem[slot_r];
  end

endmodule
`default_nettype wire

FILE: sv/wat_fifo.sv
// two-entry job queue between the front end and the divider
`default_nettype none
module wat_fifo #(
  parameter int WIDTH = 60
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push_valid,
  output logic             push_ready,
  input  wire [WIDTH-1:0]  push_data,
  output logic             pop_valid,
  input  wire              pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] buf_mem [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = buf_mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop) rd_ptr_r <= ~rd_ptr_r;
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) buf_mem[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: sv/wat_back.sv
// back end: serial divide of both totals by the fill count, alarms, output register
`default_nettype none
module wat_back #(
  parameter int  WINDOW_DEPTH = 20,
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1),
  localparam int TOTAL_W = 10 + CNT_W,
  localparam int JOB_W   = 20 + 2 * TOTAL_W + CNT_W
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              job_valid,
  output logic             job_ready,
  input  wire [JOB_W-1:0]  job_data,
  input  wire [9:0]        hum_thresh,
  input  wire [9:0]        dust_thresh,
  wat_result_if.source     out_req
);
  import wat_pkg::*;

  localparam int STEP_W = $clog2(TOTAL_W + 1);

  back_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0] hum_r, dust_r;
  logic [TOTAL_W-1:0]  hq_r, dq_r;
  logic [CNT_W-1:0]    hrem_r, drem_r;
  logic [CNT_W-1:0]    div_r;
  logic [STEP_W-1:0]   step_r;
  logic                load_job, div_step, load_out, last_step;

  logic [CNT_W:0]      hshift, dshift;
  logic                hbit, dbit;
  logic [CNT_W:0]      hdiff, ddiff;

  logic                out_valid_r;
  logic                hum_alarm_r, dust_alarm_r, avg_hum_alarm_r, avg_dust_alarm_r;
  logic [SAMPLE_W-1:0] avg_hum_r, avg_dust_r;
  logic [FILL_W-1:0]   fill_out_r;

  assign last_step = (step_r == STEP_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (job_valid) state_nxt = BK_DIV;
      BK_DIV:  if (last_step) state_nxt = BK_DONE;
      BK_DONE: if (!out_valid_r || out_req.ready) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_ready = 1'b0;
    div_step  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      BK_IDLE: job_ready = 1'b1;
      BK_DIV:  div_step  = 1'b1;
      BK_DONE: load_out  = !out_valid_r || out_req.ready;
      default: ;
    endcase
  end

  assign load_job = job_valid && job_ready;

  // one restoring step for each total
  always_comb begin
    hshift = {hrem_r, hq_r[TOTAL_W-1]};
    dshift = {drem_r, dq_r[TOTAL_W-1]};
    hdiff  = hshift - {1'b0, div_r};
    ddiff  = dshift - {1'b0, div_r};
    hbit   = (hshift >= {1'b0, div_r});
    dbit   = (dshift >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_req.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_job) begin
      {hum_r, dust_r, hq_r, dq_r, div_r} <= job_data;
      hrem_r <= '0;
      drem_r <= '0;
      step_r <= STEP_W'(TOTAL_W);
    end else if (div_step) begin
      hq_r   <= {hq_r[TOTAL_W-2:0], hbit};
      dq_r   <= {dq_r[TOTAL_W-2:0], dbit};
      hrem_r <= hbit ? hdiff[CNT_W-1:0] : hshift[CNT_W-1:0];
      drem_r <= dbit ? ddiff[CNT_W-1:0] : dshift[CNT_W-1:0];
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hum_alarm_r      <= (hum_r >= hum_thresh);
      dust_alarm_r     <= (dust_r >= dust_thresh);
      avg_hum_r        <= hq_r[SAMPLE_W-1:0];
      avg_dust_r       <= dq_r[SAMPLE_W-1:0];
      avg_hum_alarm_r  <= (hq_r >= TOTAL_W'(hum_thresh));
      avg_dust_alarm_r <= (dq_r >= TOTAL_W'(dust_thresh));
      fill_out_r       <= FILL_W'(div_r);
    end
  end

  assign out_req.valid                  = out_valid_r;
  assign out_req.humidity_alarm         = hum_alarm_r;
  assign out_req.dust_alarm             = dust_alarm_r;
  assign out_req.average_humidity       = avg_hum_r;
  assign out_req.average_dust           = avg_dust_r;
  assign out_req.average_humidity_alarm = avg_hum_alarm_r;
  assign out_req.average_dust_alarm     = avg_dust_alarm_r;
  assign out_req.window_fill            = fill_out_r;

endmodule
`default_nettype wire
